// ===== src/pacg_pkg.sv =====
// Package for the propose/acknowledge commit guard.
// Holds the transaction payload structs, queue entry, phase and opcode codes.
// No dependencies; imported by every module in src/.
package pacg_pkg;

	localparam int          QUEUE_DEPTH  = 4;
	localparam logic [15:0] WINDOW_RESET = 16'd100;

	localparam logic [1:0] KIND_OFFER  = 2'd0;
	localparam logic [1:0] KIND_TICK   = 2'd1;
	localparam logic [1:0] KIND_CANCEL = 2'd2;

	localparam logic CLASS_WEAPON = 1'b0;
	localparam logic CLASS_ITEM   = 1'b1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PENDING = 2'd1,
		PH_AWAIT   = 2'd2,
		PH_BLOCKED = 2'd3
	} phase_t;

	typedef enum logic [1:0] {
		OP_OFFER,
		OP_TICK,
		OP_CANCEL,
		OP_NONE
	} op_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [31:0]        sequence_number;
		logic [47:0]        time_ms;
		logic signed [15:0] equip_id;
		logic [1:0]         equip_class;
		logic [31:0]        epoch;
		logic [31:0]        context_tag;
		logic [31:0]        version_tag;
		logic               obs_trusted;
		logic               validation_ready;
		logic signed [15:0] weapon_seen;
		logic signed [15:0] item_seen;
	} in_item_t;

	typedef struct packed {
		logic               offer_accepted;
		logic               write_proposed;
		logic               acknowledged;
		logic [31:0]        out_sequence;
		logic signed [15:0] out_id;
		logic               out_class;
		logic [31:0]        out_epoch;
		logic [31:0]        out_context;
		logic [31:0]        out_version;
		logic [1:0]         phase_now;
	} out_item_t;

	// Classified transaction as held in the queue
	typedef struct packed {
		op_t                op;
		logic [31:0]        seq;
		logic [47:0]        now_ms;
		logic signed [15:0] id;
		logic               cls;
		logic               offer_ok;
		logic [31:0]        epoch;
		logic [31:0]        ctx;
		logic [31:0]        ver;
		logic               safe;
		logic               ready;
		logic signed [15:0] obs_weapon;
		logic signed [15:0] obs_item;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ===== src/pacg_front.sv =====
// Front end: accepts input transactions and classifies them into queue entries.
// Depends on pacg_pkg.
module pacg_front
	import pacg_pkg::*;
(
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	input  q_status_t q_status,
	output logic      push,
	output entry_t    push_data
);

	assign in_stall = q_status.full;
	assign push     = in_valid && !q_status.full;

	always_comb begin
		push_data = '0;
		unique case (in_data.kind)
			KIND_OFFER:  push_data.op = OP_OFFER;
			KIND_TICK:   push_data.op = OP_TICK;
			KIND_CANCEL: push_data.op = OP_CANCEL;
			default:     push_data.op = OP_NONE;
		endcase
		push_data.seq        = in_data.sequence_number;
		push_data.now_ms     = in_data.time_ms;
		push_data.id         = in_data.equip_id;
		push_data.cls        = in_data.equip_class[0];
		// stateless part of the offer check: nonzero seq, id >= 0, class 0 or 1
		push_data.offer_ok   = (in_data.sequence_number != 32'd0) && !in_data.equip_id[15]
			&& !in_data.equip_class[1];
		push_data.epoch      = in_data.epoch;
		push_data.ctx        = in_data.context_tag;
		push_data.ver        = in_data.version_tag;
		push_data.safe       = in_data.obs_trusted;
		push_data.ready      = in_data.validation_ready;
		push_data.obs_weapon = in_data.weapon_seen;
		push_data.obs_item   = in_data.item_seen;
	end

endmodule

// ===== src/pacg_queue.sv =====
// Short FIFO between the front and back ends.
// Depends on pacg_pkg (entry_t, q_status_t).
module pacg_queue
	import pacg_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  entry_t    push_data,
	input  logic      pop,
	output entry_t    pop_data,
	output q_status_t status
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             slot_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	assign pop_data     = slot_q[rd_ptr_q];
	assign status.full  = (count_q == CNT_W'(DEPTH));
	assign status.empty = (count_q == '0);

endmodule

// ===== src/pacg_back.sv =====
// Back end: applies queued transactions to the commit guard state and
// registers one result per transaction. Depends on pacg_pkg.
module pacg_back
	import pacg_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  entry_t      e,
	input  q_status_t   q_status,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data
);

	logic [15:0]        window_q;
	phase_t             phase_q, phase_d;
	logic [31:0]        last_offer_seq_q, last_offer_seq_d;
	logic               tick_seen_q, tick_seen_d;
	logic [31:0]        newest_tick_sn_q, newest_tick_sn_d;
	logic [31:0]        pend_seq_q, pend_seq_d;
	logic signed [15:0] pend_id_q, pend_id_d;
	logic               pend_class_q, pend_class_d;
	logic [31:0]        pend_epoch_q, pend_epoch_d;
	logic [31:0]        pend_ctx_q, pend_ctx_d;
	logic [31:0]        pend_ver_q, pend_ver_d;
	logic [47:0]        offer_time_q, offer_time_d;
	logic [47:0]        propose_time_q, propose_time_d;
	logic [47:0]        last_tick_time_q, last_tick_time_d;

	logic               out_valid_q;
	out_item_t          out_data_q;
	out_item_t          res;

	logic               fire;
	logic               fresh_offer;
	logic               newer_tick;
	logic               tags_ok;
	logic [47:0]        since_offer;
	logic [47:0]        since_prop;
	logic               in_offer_win;
	logic               prop_overrun;
	logic signed [15:0] seen;

	assign fire = !q_status.empty && (!out_valid_q || !out_stall);
	assign pop  = fire;

	assign fresh_offer  = e.seq > last_offer_seq_q;
	assign newer_tick   = !tick_seen_q || (e.seq > newest_tick_sn_q);
	assign tags_ok      = e.safe && (e.epoch == pend_epoch_q) && (e.ctx == pend_ctx_q)
		&& (e.ver == pend_ver_q);
	assign since_offer  = e.now_ms - offer_time_q;
	assign since_prop   = e.now_ms - propose_time_q;
	assign in_offer_win = (e.now_ms >= offer_time_q) && (since_offer <= {32'd0, window_q});
	assign prop_overrun = (e.now_ms < propose_time_q) || (since_prop > {32'd0, window_q});
	assign seen         = (pend_class_q == CLASS_WEAPON) ? e.obs_weapon : e.obs_item;

	always_comb begin
		phase_d          = phase_q;
		last_offer_seq_d = last_offer_seq_q;
		tick_seen_d      = tick_seen_q;
		newest_tick_sn_d = newest_tick_sn_q;
		pend_seq_d       = pend_seq_q;
		pend_id_d        = pend_id_q;
		pend_class_d     = pend_class_q;
		pend_epoch_d     = pend_epoch_q;
		pend_ctx_d       = pend_ctx_q;
		pend_ver_d       = pend_ver_q;
		offer_time_d     = offer_time_q;
		propose_time_d   = propose_time_q;
		last_tick_time_d = last_tick_time_q;
		res              = '0;

		if (fire) begin
			unique case (e.op)
				OP_OFFER: begin
					if (fresh_offer) begin
						last_offer_seq_d = e.seq;
						if (phase_q == PH_IDLE && e.offer_ok) begin
							pend_seq_d         = e.seq;
							pend_id_d          = e.id;
							pend_class_d       = e.cls;
							pend_epoch_d       = e.epoch;
							pend_ctx_d         = e.ctx;
							pend_ver_d         = e.ver;
							offer_time_d       = e.now_ms;
							phase_d            = PH_PENDING;
							res.offer_accepted = 1'b1;
							res.out_sequence   = e.seq;
							res.out_id         = e.id;
							res.out_class      = e.cls;
							res.out_epoch      = e.epoch;
							res.out_context    = e.ctx;
							res.out_version    = e.ver;
						end
					end
				end
				OP_TICK: begin
					unique case (phase_q)
						PH_PENDING: begin
							// pending intent is consumed either way
							phase_d     = PH_IDLE;
							tick_seen_d = 1'b1;
							if (newer_tick) begin
								newest_tick_sn_d = e.seq;
							end
							if (tags_ok && e.ready && in_offer_win && newer_tick) begin
								propose_time_d     = e.now_ms;
								last_tick_time_d   = e.now_ms;
								phase_d            = PH_AWAIT;
								res.write_proposed = 1'b1;
							end
						end
						PH_AWAIT: begin
							if (!tags_ok || (e.now_ms < last_tick_time_q) || prop_overrun
								|| (e.seq < newest_tick_sn_q)) begin
								phase_d = PH_BLOCKED;
							end else begin
								last_tick_time_d = e.now_ms;
								// a repeated sequence only refreshes the tick time
								if (e.seq != newest_tick_sn_q) begin
									newest_tick_sn_d = e.seq;
									if (seen == pend_id_q) begin
										res.acknowledged = 1'b1;
										phase_d          = PH_IDLE;
									end
								end
							end
						end
						default: begin
							tick_seen_d = 1'b1;
							if (newer_tick) begin
								newest_tick_sn_d = e.seq;
							end
						end
					endcase
					if (res.write_proposed || res.acknowledged) begin
						res.out_sequence = pend_seq_q;
						res.out_id       = pend_id_q;
						res.out_class    = pend_class_q;
						res.out_epoch    = pend_epoch_q;
						res.out_context  = pend_ctx_q;
						res.out_version  = pend_ver_q;
					end
				end
				OP_CANCEL: begin
					if (phase_q == PH_AWAIT) begin
						phase_d = PH_BLOCKED;
					end else if (phase_q == PH_PENDING) begin
						phase_d = PH_IDLE;
					end
				end
				default: begin
				end
			endcase
		end
		res.phase_now = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q         <= WINDOW_RESET;
			last_offer_seq_q <= '0;
			tick_seen_q      <= 1'b0;
			newest_tick_sn_q <= '0;
			pend_seq_q       <= '0;
			pend_id_q        <= '0;
			pend_class_q     <= 1'b0;
			pend_epoch_q     <= '0;
			pend_ctx_q       <= '0;
			pend_ver_q       <= '0;
			offer_time_q     <= '0;
			propose_time_q   <= '0;
			last_tick_time_q <= '0;
			out_valid_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				window_q <= cfg_wdata;
			end
			last_offer_seq_q <= last_offer_seq_d;
			tick_seen_q      <= tick_seen_d;
			newest_tick_sn_q <= newest_tick_sn_d;
			pend_seq_q       <= pend_seq_d;
			pend_id_q        <= pend_id_d;
			pend_class_q     <= pend_class_d;
			pend_epoch_q     <= pend_epoch_d;
			pend_ctx_q       <= pend_ctx_d;
			pend_ver_q       <= pend_ver_d;
			offer_time_q     <= offer_time_d;
			propose_time_q   <= propose_time_d;
			last_tick_time_q <= last_tick_time_d;
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_data_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== src/propose_ack_commit_guard_unit.sv =====
// Top level of the propose/acknowledge commit guard: front end, queue, back end.
// Depends on pacg_pkg, pacg_front, pacg_queue, pacg_back.
//
// Takes one transaction per clock while in_stall is low and returns exactly
// one result per transaction, in order. An accepted transaction is written into
// a QUEUE_DEPTH_P-entry queue; the back end pops it, applies it to the guard
// state and holds the result in an output register that drives out_valid.
// The sustained rate is one transaction per cycle while out_stall is low, set
// by the back end's state update (tag compares plus a 48-bit time difference
// against the window).
// The queue absorbs output stalls; in_stall rises only when it is full. The
// commit window resets to 100 and is written through cfg_we/cfg_wdata; the user
// must write it only while no transaction is in flight (the block does not enforce this).
module propose_ack_commit_guard_unit
	import pacg_pkg::*;
#(
	parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  in_item_t    in_data,
	output logic        out_valid,
	input  logic        out_stall,
	output out_item_t   out_data,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	q_status_t q_status;
	logic      push;
	entry_t    push_data;
	logic      pop;
	entry_t    pop_data;

	pacg_front u_front (
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.q_status  (q_status),
		.push      (push),
		.push_data (push_data)
	);

	pacg_queue #(
		.DEPTH (QUEUE_DEPTH_P)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (q_status)
	);

	pacg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.e         (pop_data),
		.q_status  (q_status),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

`ifndef SYNTH
	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({out_data.offer_accepted, out_data.write_proposed,
			out_data.acknowledged}))
		else $error("more than one result flag set");

	a_flag_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |->
			(!out_data.offer_accepted || out_data.phase_now == PH_PENDING) &&
			(!out_data.write_proposed || out_data.phase_now == PH_AWAIT) &&
			(!out_data.acknowledged || out_data.phase_now == PH_IDLE))
		else $error("result flag disagrees with reported phase");

	a_report_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.offer_accepted || out_data.write_proposed ||
			out_data.acknowledged)) |-> (out_data.out_sequence != 32'd0))
		else $error("reported intent with zero sequence");
`endif

endmodule

// ===== tb/propose_ack_commit_guard_unit_tb.sv =====
// Self-checking testbench for propose_ack_commit_guard_unit: a queue-fed driver, a
// predicting monitor, and directed plus random offer/tick/cancel traffic.
// Depends on pacg_pkg and the RTL in src/.
`timescale 1ns / 100ps

module propose_ack_commit_guard_unit_tb;
	import pacg_pkg::*;

	localparam logic [1:0]  KIND_UNUSED  = 2'd3;
	localparam logic [1:0]  CLASS_OTHER  = 2'd2;
	localparam logic [1:0]  CLASS_UNUSED = 2'd3;
	localparam logic [47:0] TIME_MAX     = '1;

	typedef enum logic [1:0] {IDLE_NONE, IDLE_TX, IDLE_RX, IDLE_BOTH} idle_mode_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] window;
		logic [31:0] last_offer_seq;
		logic        tick_seen;
		logic [31:0] newest_tick_sn;
		logic [31:0] pend_seq;
		logic [15:0] pend_id;
		logic        pend_cls;
		logic [31:0] pend_epoch, pend_ctx, pend_ver;
		logic [47:0] offer_t, propose_t, last_tick_t;
	} guard_state_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = WINDOW_RESET;

	// dut_view follows accepted transactions; plan_view runs ahead with the stimulus
	guard_state_t dut_view, plan_view;
	in_item_t     txn_backlog[$];
	out_item_t    verdict_q[$];
	out_item_t    exp_v, next_v;
	idle_mode_t   idle_mode = IDLE_NONE;
	int           mismatches = 0;

	propose_ack_commit_guard_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void note_tick(inout guard_state_t st, input logic [31:0] seq);
		if (!st.tick_seen || seq > st.newest_tick_sn)
			st.newest_tick_sn = seq;
		st.tick_seen = 1'b1;
	endfunction

	function automatic out_item_t commit_guard_step(inout guard_state_t st, input in_item_t it);
		out_item_t   r;
		logic        stale, tags_ok, report;
		logic [15:0] seen;
		r = '0;
		report = 1'b0;
		case (it.kind)
			KIND_OFFER: begin
				if (it.sequence_number != 0 && it.sequence_number > st.last_offer_seq) begin
					st.last_offer_seq = it.sequence_number;
					if (st.phase == PH_IDLE && !it.equip_id[15] && it.equip_class <= 2'd1) begin
						st.pend_seq = it.sequence_number;
						st.pend_id = it.equip_id;
						st.pend_cls = it.equip_class[0];
						st.pend_epoch = it.epoch;
						st.pend_ctx = it.context_tag;
						st.pend_ver = it.version_tag;
						st.offer_t = it.time_ms;
						st.phase = PH_PENDING;
						r.offer_accepted = 1'b1;
						report = 1'b1;
					end
				end
			end
			KIND_TICK: begin
				stale = st.tick_seen && it.sequence_number <= st.newest_tick_sn;
				tags_ok = it.obs_trusted && it.epoch == st.pend_epoch &&
					it.context_tag == st.pend_ctx && it.version_tag == st.pend_ver;
				case (st.phase)
					PH_PENDING: begin
						// the intent is consumed whether or not it gets proposed
						st.phase = PH_IDLE;
						note_tick(st, it.sequence_number);
						if (tags_ok && it.validation_ready && it.time_ms >= st.offer_t &&
							it.time_ms - st.offer_t <= st.window && !stale) begin
							st.propose_t = it.time_ms;
							st.last_tick_t = it.time_ms;
							st.newest_tick_sn = it.sequence_number;
							st.phase = PH_AWAIT;
							r.write_proposed = 1'b1;
							report = 1'b1;
						end
					end
					PH_AWAIT: begin
						if (!tags_ok || it.time_ms < st.last_tick_t || it.time_ms < st.propose_t ||
							it.time_ms - st.propose_t > st.window ||
							it.sequence_number < st.newest_tick_sn) begin
							st.phase = PH_BLOCKED;
						end else begin
							st.last_tick_t = it.time_ms;
							// a repeated sequence only refreshes the tick time
							if (it.sequence_number != st.newest_tick_sn) begin
								seen = st.pend_cls ? it.item_seen : it.weapon_seen;
								st.newest_tick_sn = it.sequence_number;
								if (seen == st.pend_id) begin
									r.acknowledged = 1'b1;
									report = 1'b1;
									st.phase = PH_IDLE;
								end
							end
						end
					end
					default: note_tick(st, it.sequence_number);
				endcase
			end
			KIND_CANCEL: begin
				if (st.phase == PH_AWAIT)
					st.phase = PH_BLOCKED;
				else if (st.phase == PH_PENDING)
					st.phase = PH_IDLE;
			end
			default: ;
		endcase
		if (report) begin
			r.out_sequence = st.pend_seq;
			r.out_id = st.pend_id;
			r.out_class = st.pend_cls;
			r.out_epoch = st.pend_epoch;
			r.out_context = st.pend_ctx;
			r.out_version = st.pend_ver;
		end
		r.phase_now = st.phase;
		return r;
	endfunction

	function automatic in_item_t offer_it(input logic [31:0] seq, input logic [47:0] t,
		input logic [15:0] id, input logic [1:0] cls);
		in_item_t it;
		it = '0;
		it.kind = KIND_OFFER;
		it.sequence_number = seq;
		it.time_ms = t;
		it.equip_id = id;
		it.equip_class = cls;
		it.epoch = $urandom;
		it.context_tag = $urandom;
		it.version_tag = $urandom;
		return it;
	endfunction

	// tick that carries the tags of the intent currently pending in plan_view
	function automatic in_item_t tick_it(input logic [31:0] seq, input logic [47:0] t,
		input logic [15:0] obs_w, input logic [15:0] obs_i);
		in_item_t it;
		it = '0;
		it.kind = KIND_TICK;
		it.sequence_number = seq;
		it.time_ms = t;
		it.epoch = plan_view.pend_epoch;
		it.context_tag = plan_view.pend_ctx;
		it.version_tag = plan_view.pend_ver;
		it.obs_trusted = 1'b1;
		it.validation_ready = 1'b1;
		it.weapon_seen = obs_w;
		it.item_seen = obs_i;
		return it;
	endfunction

	// one defect per tick: a tag bit, safety, readiness, time below or above range, old sequence
	function automatic in_item_t spoil_tick(input in_item_t it, input logic [47:0] t_low,
		input logic [47:0] t_high);
		case ($urandom_range(7))
			0: it.epoch ^= 32'd1 << $urandom_range(31);
			1: it.context_tag ^= 32'd1 << $urandom_range(31);
			2: it.version_tag ^= 32'd1 << $urandom_range(31);
			3: it.obs_trusted = 1'b0;
			4: it.time_ms = t_low - 48'd1 - $urandom_range(50);
			5: it.time_ms = t_high + 48'd1 + $urandom_range(50);
			6: it.sequence_number = (plan_view.newest_tick_sn == 0) ? 32'd0 :
				plan_view.newest_tick_sn - 32'd1;
			default: it.validation_ready = 1'b0;
		endcase
		if (it.epoch == plan_view.pend_epoch && it.context_tag == plan_view.pend_ctx &&
			it.version_tag == plan_view.pend_ver && it.obs_trusted &&
			it.validation_ready && it.time_ms == t_low)
			it.obs_trusted = 1'b0;
		return it;
	endfunction

	// mostly well-formed offer/propose/acknowledge flows; blocking only when may_block
	function automatic in_item_t rand_item(input bit may_block);
		in_item_t    it;
		logic [255:0] noise;
		logic [63:0] lim;
		logic [47:0] t;
		int unsigned pick, k;
		noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		it = noise[$bits(in_item_t)-1:0];
		pick = $urandom_range(99);
		case (plan_view.phase)
			PH_IDLE: begin
				if (pick < 75) begin
					k = $urandom_range(9);
					t = (k == 0) ? 48'($urandom_range(200)) :
						(k == 1) ? TIME_MAX - $urandom_range(200) : it.time_ms;
					it = offer_it(plan_view.last_offer_seq + $urandom_range(1, 3), t,
						{1'b0, it.equip_id[14:0]}, {1'b0, it.equip_class[0]});
				end else if (pick < 85) begin
					it.kind = KIND_OFFER;
					k = $urandom_range(3);
					it.sequence_number = (k == 0) ? 32'd0 : (k == 1) ? plan_view.last_offer_seq :
						plan_view.last_offer_seq + $urandom_range(1, 3);
					if (k == 2)
						it.equip_id[15] = 1'b1;
					if (k == 3)
						it.equip_class[1] = 1'b1;
				end else if (pick < 93) begin
					it.kind = KIND_TICK;
					it.sequence_number = plan_view.newest_tick_sn + $urandom_range(2);
				end else
					it.kind = (pick < 97) ? KIND_CANCEL : KIND_UNUSED;
			end
			PH_PENDING: begin
				if (pick < 80) begin
					lim = plan_view.offer_t + plan_view.window;
					if (lim > TIME_MAX)
						lim = TIME_MAX;
					it = tick_it(plan_view.newest_tick_sn + $urandom_range(1, 3),
						plan_view.offer_t + $urandom_range(0, lim - plan_view.offer_t),
						it.weapon_seen, it.item_seen);
					if ($urandom_range(99) < 30)
						it = spoil_tick(it, plan_view.offer_t, plan_view.offer_t + plan_view.window);
				end else if (pick < 88) begin
					it.kind = KIND_CANCEL;
				end else if (pick < 95) begin
					it.kind = KIND_OFFER;
					it.sequence_number = plan_view.last_offer_seq + $urandom_range(2);
				end else
					it.kind = KIND_UNUSED;
			end
			PH_AWAIT: begin
				if (pick < 80) begin
					lim = plan_view.propose_t + plan_view.window;
					if (lim > TIME_MAX)
						lim = TIME_MAX;
					it = tick_it(plan_view.newest_tick_sn +
						(($urandom_range(99) < 20) ? 0 : $urandom_range(1, 3)),
						plan_view.last_tick_t + $urandom_range(0, lim - plan_view.last_tick_t),
						it.weapon_seen, it.item_seen);
					it.validation_ready = $urandom_range(1);
					if ($urandom_range(1)) begin
						if (plan_view.pend_cls)
							it.item_seen = plan_view.pend_id;
						else
							it.weapon_seen = plan_view.pend_id;
					end
					if (may_block && $urandom_range(99) < 8)
						it = spoil_tick(it, plan_view.last_tick_t,
							plan_view.propose_t + plan_view.window);
				end else if (pick < 90) begin
					it.kind = KIND_OFFER;
					it.sequence_number = plan_view.last_offer_seq + $urandom_range(2);
				end else
					it.kind = (may_block && pick < 95) ? KIND_CANCEL : KIND_UNUSED;
			end
			default: ;
		endcase
		return it;
	endfunction

	task automatic queue_item(input in_item_t it);
		void'(commit_guard_step(plan_view, it));
		txn_backlog.push_back(it);
	endtask

	task automatic wait_quiet();
		do
			@(negedge clk);
		while (txn_backlog.size() != 0 || in_valid || verdict_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_window(input logic [15:0] w);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= w;
		dut_view.window = w;
		plan_view.window = w;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic note_field(input string fld, input logic [63:0] want, input logic [63:0] got);
		mismatches++;
		$display("%0t: %s expected %0h, got %0h", $time, fld, want, got);
	endtask

	// driver: the prediction is taken when the transaction is accepted
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				next_v = commit_guard_step(dut_view, in_data);
				verdict_q.push_back(next_v);
			end
			if (!in_valid || !in_stall) begin
				if (txn_backlog.size() != 0 && !((idle_mode == IDLE_TX || idle_mode == IDLE_BOTH) &&
					$urandom_range(99) < ((idle_mode == IDLE_BOTH) ? 21 : 81))) begin
					in_data <= txn_backlog.pop_front();
					in_valid <= 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (verdict_q.size() == 0) begin
					mismatches++;
					$display("%0t: transaction with none expected, expected nothing, got %h",
						$time, out_data);
				end else begin
					exp_v = verdict_q.pop_front();
					if (out_data.offer_accepted !== exp_v.offer_accepted)
						note_field("offer_accepted", exp_v.offer_accepted, out_data.offer_accepted);
					if (out_data.write_proposed !== exp_v.write_proposed)
						note_field("write_proposed", exp_v.write_proposed, out_data.write_proposed);
					if (out_data.acknowledged !== exp_v.acknowledged)
						note_field("acknowledged", exp_v.acknowledged, out_data.acknowledged);
					if (out_data.out_sequence !== exp_v.out_sequence)
						note_field("out_sequence", exp_v.out_sequence, out_data.out_sequence);
					if (out_data.out_id !== exp_v.out_id)
						note_field("out_id", $unsigned(exp_v.out_id), $unsigned(out_data.out_id));
					if (out_data.out_class !== exp_v.out_class)
						note_field("out_class", exp_v.out_class, out_data.out_class);
					if (out_data.out_epoch !== exp_v.out_epoch)
						note_field("out_epoch", exp_v.out_epoch, out_data.out_epoch);
					if (out_data.out_context !== exp_v.out_context)
						note_field("out_context", exp_v.out_context, out_data.out_context);
					if (out_data.out_version !== exp_v.out_version)
						note_field("out_version", exp_v.out_version, out_data.out_version);
					if (out_data.phase_now !== exp_v.phase_now)
						note_field("phase_now", exp_v.phase_now, out_data.phase_now);
				end
			end
			out_stall <= (idle_mode == IDLE_RX || idle_mode == IDLE_BOTH) &&
				($urandom_range(99) < ((idle_mode == IDLE_BOTH) ? 21 : 81));
		end
	end

	initial begin
		#10_000_000;
		$display("propose_ack_commit_guard_unit_tb failed");
		$finish;
	end

	initial begin
		in_item_t    it;
		int unsigned ph, n;
		logic [15:0] w;
		dut_view = '0;
		dut_view.window = WINDOW_RESET;
		plan_view = dut_view;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle noise, refused offers, cancel of a pending intent
		queue_item(tick_it(32'd5, '0, '0, '0));
		it = '0;
		it.kind = KIND_CANCEL;
		queue_item(it);
		it.kind = KIND_UNUSED;
		queue_item(it);
		queue_item(offer_it(32'd0, '0, 16'd1, CLASS_WEAPON));
		queue_item(offer_it(32'd10, '0, 16'hFFFF, CLASS_WEAPON));
		queue_item(offer_it(32'd10, '0, 16'd1, CLASS_WEAPON));
		queue_item(offer_it(32'd11, '0, 16'd1, CLASS_OTHER));
		queue_item(offer_it(32'd12, '0, 16'd1, CLASS_UNUSED));
		it = offer_it(32'd13, '0, 16'h7FFF, CLASS_ITEM);
		it.epoch = '1;
		it.context_tag = '0;
		it.version_tag = '1;
		queue_item(it);
		queue_item(offer_it(32'd14, '0, 16'd1, CLASS_WEAPON));
		it = '0;
		it.kind = KIND_CANCEL;
		queue_item(it);

		// proposal right at the window edge near the top of the time range, then ack
		queue_item(offer_it(32'd15, TIME_MAX - 48'd100, 16'd0, CLASS_WEAPON));
		queue_item(tick_it(32'd6, TIME_MAX, 16'd0, 16'h8000));
		queue_item(tick_it(32'd6, TIME_MAX, 16'd0, 16'h8000));
		queue_item(tick_it(32'd7, TIME_MAX, 16'd1, 16'd0));
		queue_item(tick_it(32'd8, TIME_MAX, 16'd0, 16'h8000));

		// dropped proposals: window overrun, early time, stale tick, not ready, unsafe
		queue_item(offer_it(32'd16, 48'd1000, 16'd5, CLASS_ITEM));
		queue_item(tick_it(32'd9, 48'd1101, 16'd0, 16'd5));
		queue_item(offer_it(32'd17, 48'd1000, 16'd5, CLASS_ITEM));
		queue_item(tick_it(32'd10, 48'd999, 16'd0, 16'd5));
		queue_item(offer_it(32'd18, 48'd1000, 16'd5, CLASS_ITEM));
		queue_item(tick_it(32'd10, 48'd1000, 16'd0, 16'd5));
		queue_item(offer_it(32'd19, 48'd2000, 16'd5, CLASS_ITEM));
		it = tick_it(32'd11, 48'd2000, 16'd0, 16'd5);
		it.validation_ready = 1'b0;
		queue_item(it);
		queue_item(offer_it(32'd20, 48'd2000, 16'd5, CLASS_ITEM));
		it = tick_it(32'd12, 48'd2050, 16'd0, 16'd5);
		it.obs_trusted = 1'b0;
		queue_item(it);

		// item-class acknowledgement
		queue_item(offer_it(32'd21, 48'd3000, 16'h1234, CLASS_ITEM));
		queue_item(tick_it(32'd13, 48'd3050, 16'd0, 16'd0));
		queue_item(tick_it(32'd14, 48'd3100, 16'h4321, 16'h1234));

		for (ph = 0; ph < 8; ph++) begin
			wait_quiet();
			case (ph)
				0: w = 16'd0;
				1: w = 16'hFFFF;
				2: w = 16'd1;
				7: w = WINDOW_RESET;
				default: w = $urandom_range(2, 400);
			endcase
			set_window(w);
			idle_mode = idle_mode_t'(ph % 4);
			for (n = 0; n < 200; n++) begin
				// hold the sender until everything in flight has come back
				if (n == 100)
					wait_quiet();
				queue_item(rand_item(1'b0));
			end
		end

		// blocking phase: once blocked the guard stays there until reset
		wait_quiet();
		set_window(WINDOW_RESET);
		idle_mode = IDLE_BOTH;
		for (n = 0; n < 150; n++)
			queue_item(rand_item(1'b1));
		if (plan_view.phase == PH_PENDING) begin
			it = '0;
			it.kind = KIND_CANCEL;
			queue_item(it);
		end
		if (plan_view.phase == PH_AWAIT)
			queue_item(tick_it(plan_view.newest_tick_sn + 32'd1, plan_view.last_tick_t,
				plan_view.pend_id, plan_view.pend_id));
		if (plan_view.phase == PH_IDLE) begin
			queue_item(offer_it(plan_view.last_offer_seq + 32'd1, 48'd5000, 16'h0042,
				CLASS_WEAPON));
			queue_item(tick_it(plan_view.newest_tick_sn + 32'd1, 48'd5000, '0, '0));
			it = '0;
			it.kind = KIND_CANCEL;
			queue_item(it);
		end
		queue_item(tick_it(32'hFFFF_FFFF, TIME_MAX, 16'h7FFF, 16'h8000));
		queue_item(offer_it(32'hFFFF_FFFF, TIME_MAX, 16'h7FFF, CLASS_ITEM));
		it = '0;
		it.kind = KIND_CANCEL;
		queue_item(it);
		it.kind = KIND_UNUSED;
		queue_item(it);
		for (n = 0; n < 100; n++)
			queue_item(rand_item(1'b1));

		wait_quiet();
		repeat (8) @(negedge clk);
		if (mismatches == 0)
			$display("propose_ack_commit_guard_unit_tb passed");
		else
			$display("propose_ack_commit_guard_unit_tb failed");
		$finish;
	end

endmodule
